FILE: rtl/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// shared constants, command codes and controller/datapath signal groups
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefWordWidth = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned PosW         = 5;
  localparam int unsigned DataW        = 32;
  localparam int unsigned StatW        = 2;
  localparam int unsigned CapW         = 5;
  localparam int unsigned LenW         = 5;

  localparam logic [KindW-1:0] KIND_APPEND  = 3'd0;
  localparam logic [KindW-1:0] KIND_INSERT  = 3'd1;
  localparam logic [KindW-1:0] KIND_DELETE  = 3'd2;
  localparam logic [KindW-1:0] KIND_REVERSE = 3'd3;
  localparam logic [KindW-1:0] KIND_SORT    = 3'd4;
  localparam logic [KindW-1:0] KIND_DUMP    = 3'd5;
  localparam logic [KindW-1:0] KIND_CLEAR   = 3'd6;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_BAD   = 2'd2;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd3;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,    // capture command fields
    OP_RD_A,     // read entry at idx a
    OP_RD_B,     // read entry at idx b
    OP_HOLD_A,   // keep read data in a register
    OP_WR_A_B,   // write read data (entry b) to idx a
    OP_WR_B_A,   // write held a to b
    OP_WR_A_RD,  // write read data to idx a
    OP_WR_A_VAL, // write command value to idx a
    OP_CNT_INC,
    OP_CNT_DEC,
    OP_CNT_CLR
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [6:0]  idx_a;   // wide enough for any depth in range
    logic [6:0]  idx_b;
    logic        emit;
    logic [StatW-1:0] status;
    logic        use_rd;  // data output from read data
    logic        use_hold; // data output from the hold register
    logic        last;
  } dp_cmd_t;

  typedef struct packed {
    logic        a_gt_b;  // held a above read b, signed
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/sle_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ram
// generic single-port-write ram with one registered read port
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/sle_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_datapath
// element store, count, hold registers and result register
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; #(
  parameter int unsigned Depth     = DefDepth,
  parameter int unsigned WordWidth = DefWordWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  input  wire logic [DataW-1:0] value_i,
  output dp_stat_t              stat_o,
  output logic [LenW-1:0]       count_o,
  output logic                  done_o,
  output logic [StatW-1:0]      status_o,
  output logic [DataW-1:0]      data_o,
  output logic                  last_o
);
  localparam int unsigned AW = $clog2(Depth);

  logic [WordWidth-1:0] rdata, hold_q, val_q, wdata;
  logic [AW-1:0]        waddr, raddr;
  logic                 we;
  logic [LenW-1:0]      count_q;
  logic [DataW-1:0]     rd_data;

  // sign-extend or cut the 32 bit input into a stored word
  function automatic logic [WordWidth-1:0] to_word(input logic [DataW-1:0] v);
    logic [63:0] ext;
    ext = {{32{v[DataW-1]}}, v};
    return ext[WordWidth-1:0];
  endfunction

  function automatic logic [DataW-1:0] to_data(input logic [WordWidth-1:0] w);
    logic [127:0] ext;
    ext = {{(128-WordWidth){w[WordWidth-1]}}, w};
    return ext[DataW-1:0];
  endfunction

  assign raddr = (cmd_i.op == OP_RD_B) ? cmd_i.idx_b[AW-1:0] : cmd_i.idx_a[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.idx_a[AW-1:0];
    wdata = rdata;
    case (cmd_i.op)
      OP_WR_A_B: begin
        we = 1'b1; wdata = rdata;
      end
      OP_WR_B_A: begin
        we = 1'b1; waddr = cmd_i.idx_b[AW-1:0]; wdata = hold_q;
      end
      OP_WR_A_RD: begin
        we = 1'b1;
      end
      OP_WR_A_VAL: begin
        we = 1'b1; wdata = val_q;
      end
      default: ;
    endcase
  end

  sle_ram #(.Width(WordWidth), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign stat_o.a_gt_b = $signed(hold_q) > $signed(rdata);
  assign rd_data       = to_data(rdata);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) val_q <= to_word(value_i);
    if (cmd_i.op == OP_HOLD_A) hold_q <= rdata;
    if (cmd_i.emit) begin
      status_o <= cmd_i.status;
      data_o   <= cmd_i.use_rd ? rd_data : (cmd_i.use_hold ? to_data(hold_q) : '0);
      last_o   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= cmd_i.emit;
      unique case (cmd_i.op)
        OP_CNT_INC: count_q <= count_q + LenW'(1);
        OP_CNT_DEC: count_q <= count_q - LenW'(1);
        OP_CNT_CLR: count_q <= '0;
        default: ;
      endcase
    end
  end

  assign count_o = count_q;

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Depth) else $error("count beyond depth");
  inc_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_CNT_INC |=> count_q == $past(count_q) + LenW'(1))
    else $error("count increment lost");
  dec_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_CNT_DEC |-> count_q != '0) else $error("count underflow");
endmodule
`default_nettype wire

FILE: rtl/sle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl
// command sequencer driving the datapath one ram access per cycle
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KindW-1:0] kind_i,
  input  wire logic [PosW-1:0]  position_i,
  input  wire logic [CapW-1:0]  capacity_i,
  input  wire logic [LenW-1:0]  count_i,
  input  wire dp_stat_t         stat_i,
  output dp_cmd_t               cmd_o,
  output logic                  busy_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SHR    = 4'd2;  // insert: read i-1
  localparam logic [3:0] S_SHRW   = 4'd3;  // insert: write i
  localparam logic [3:0] S_INSW   = 4'd4;
  localparam logic [3:0] S_DRD    = 4'd5;  // delete: read target
  localparam logic [3:0] S_DOUT   = 4'd6;
  localparam logic [3:0] S_SHL    = 4'd7;
  localparam logic [3:0] S_SHLW   = 4'd8;
  localparam logic [3:0] S_PRA    = 4'd9;  // pair: read a
  localparam logic [3:0] S_PHA    = 4'd10; // pair: hold a
  localparam logic [3:0] S_PCMP   = 4'd11; // pair: read b
  localparam logic [3:0] S_PWB    = 4'd12; // pair: compare / write a
  localparam logic [3:0] S_DMPR   = 4'd13;
  localparam logic [3:0] S_DMPE   = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  localparam int unsigned IW = 7;

  logic [3:0]       state_q, state_d;
  logic [KindW-1:0] kind_q;
  logic [PosW-1:0]  pos_q;
  logic [IW-1:0]    i_q, i_d, j_q, j_d;
  logic [StatW-1:0] fst_q, fst_d;
  logic [IW-1:0]    cap, cnt, pos;
  logic             full;

  assign cnt  = IW'(count_i);
  assign pos  = IW'(pos_q);
  assign cap  = (32'(capacity_i) > Depth) ? IW'(Depth) : IW'(capacity_i);
  assign full = cnt >= cap;
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    fst_d   = fst_q;
    cmd_o   = '0;
    cmd_o.op = OP_NONE;
    cmd_o.idx_a = i_q;
    cmd_o.idx_b = j_q;
    cmd_o.status = fst_q;
    cmd_o.last = 1'b1;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.op = OP_LATCH;
        state_d  = S_DISP;
      end
      S_DISP: begin
        fst_d   = STAT_OK;
        state_d = S_FIN;
        case (kind_q)
          KIND_APPEND: begin
            if (full) fst_d = STAT_FULL;
            else begin
              i_d = cnt; state_d = S_INSW;
            end
          end
          KIND_INSERT: begin
            if (full) fst_d = STAT_FULL;
            else if (pos < 7'd1 || pos > cnt + 7'd1) fst_d = STAT_BAD;
            else begin
              i_d = cnt;
              state_d = (cnt > pos - 7'd1) ? S_SHR : S_INSW;
            end
          end
          KIND_DELETE: begin
            if (pos < 7'd1 || pos > cnt) fst_d = STAT_BAD;
            else begin
              i_d = pos - 7'd1; state_d = S_DRD;
            end
          end
          KIND_REVERSE: if (cnt > 7'd1) begin
            i_d = '0; j_d = cnt - 7'd1; state_d = S_PRA;
          end
          KIND_SORT: if (cnt > 7'd1) begin
            i_d = '0; j_d = 7'd1; state_d = S_PRA;
          end
          KIND_DUMP: begin
            if (cnt == '0) fst_d = STAT_EMPTY;
            else begin
              i_d = '0; state_d = S_DMPR;
            end
          end
          KIND_CLEAR: cmd_o.op = OP_CNT_CLR;
          default: ;
        endcase
      end
      // insert shift: store[i] = store[i-1] for i from count down to pos
      S_SHR: begin
        cmd_o.op = OP_RD_A; cmd_o.idx_a = i_q - 7'd1; state_d = S_SHRW;
      end
      S_SHRW: begin
        cmd_o.op = OP_WR_A_RD;
        i_d = i_q - 7'd1;
        state_d = (i_q - 7'd1 > pos - 7'd1) ? S_SHR : S_INSW;
      end
      S_INSW: begin
        cmd_o.op = OP_WR_A_VAL; cmd_o.idx_a = i_q; state_d = S_FIN;
        i_d = '1;
      end
      S_DRD: begin
        cmd_o.op = OP_RD_A; state_d = S_DOUT;
      end
      // keep the deleted word for the result in the final cycle
      S_DOUT: begin
        cmd_o.op = OP_HOLD_A;
        state_d = (i_q + 7'd1 < cnt) ? S_SHL : S_FIN;
        i_d = i_q;
      end
      S_SHL: begin
        cmd_o.op = OP_RD_A; cmd_o.idx_a = i_q + 7'd1; state_d = S_SHLW;
      end
      S_SHLW: begin
        cmd_o.op = OP_WR_A_RD;
        i_d = i_q + 7'd1;
        state_d = (i_q + 7'd2 < cnt) ? S_SHL : S_FIN;
      end
      S_PRA: begin
        cmd_o.op = OP_RD_A; state_d = S_PHA;
      end
      S_PHA: begin
        cmd_o.op = OP_HOLD_A; state_d = S_PCMP;
      end
      S_PCMP: begin
        // read b now, compare next
        cmd_o.op = OP_RD_B; state_d = S_PWB;
      end
      S_PWB: begin
        if (kind_q == KIND_REVERSE || stat_i.a_gt_b) begin
          cmd_o.op = OP_WR_A_B;  // store[a] = read b
          state_d = S_DMPE;      // then write held a to b
        end else begin
          state_d = S_PRA;
          if (kind_q == KIND_SORT) begin
            if (j_q + 7'd1 < cnt) j_d = j_q + 7'd1;
            else if (i_q + 7'd2 < cnt) begin
              i_d = i_q + 7'd1; j_d = i_q + 7'd2;
            end else state_d = S_FIN;
          end
        end
      end
      S_DMPE: begin
        if (kind_q == KIND_DUMP) begin
          cmd_o.emit = 1'b1; cmd_o.use_rd = 1'b1; cmd_o.status = STAT_OK;
          cmd_o.last = (i_q + 7'd1 == cnt);
          i_d = i_q + 7'd1;
          state_d = (i_q + 7'd1 == cnt) ? S_IDLE : S_DMPR;
        end else begin
          cmd_o.op = OP_WR_B_A;
          state_d = S_PRA;
          if (kind_q == KIND_REVERSE) begin
            i_d = i_q + 7'd1; j_d = j_q - 7'd1;
            if (i_q + 7'd1 >= j_q - 7'd1) state_d = S_FIN;
          end else begin
            if (j_q + 7'd1 < cnt) j_d = j_q + 7'd1;
            else if (i_q + 7'd2 < cnt) begin
              i_d = i_q + 7'd1; j_d = i_q + 7'd2;
            end else state_d = S_FIN;
          end
        end
      end
      S_DMPR: begin
        cmd_o.op = OP_RD_A; state_d = S_DMPE;
      end
      // result word leaves with the count update so length is current
      S_FIN: begin
        state_d = S_IDLE;
        cmd_o.emit = 1'b1;
        if (kind_q == KIND_DELETE && fst_q == STAT_OK) begin
          cmd_o.op = OP_CNT_DEC;
          cmd_o.use_hold = 1'b1;
        end else if ((kind_q == KIND_APPEND || kind_q == KIND_INSERT) &&
                     fst_q == STAT_OK) begin
          cmd_o.op = OP_CNT_INC;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      fst_q   <= STAT_OK;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      fst_q   <= fst_d;
    end
  end

  idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !cmd_o.emit) else $error("result while idle");
  acc_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && start_i |=> state_q == S_DISP) else $error("start lost");
  ptr_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PRA |-> 32'(i_q) < Depth && 32'(j_q) < Depth)
    else $error("pair index out of range");
endmodule
`default_nettype wire

FILE: rtl/sequential_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine
// ordered list of signed words with append, insert, delete, reverse, sort,
// dump and clear commands
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// command   in         start & !busy          kind_i, position_i, value_i
// result    out        done_o (one cycle)     status_o, data_o, last_o, length_o
// config    in         capacity_we_i          capacity_i
//
// insert shifts the words from the position on up one by one, delete shifts
// the words behind the target down, dump reads out each word, reverse swaps
// pairs from both ends inward and sort compares pairs and swaps those out of
// order. the controller issues one ram read or one write per cycle;
// busy drops in the cycle of the last result word.
// asynchronous active-low reset empties the list and sets capacity to 16,
// capped at the depth; store contents are not cleared. results cannot be stalled.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
  parameter int unsigned Depth     = DefDepth,
  parameter int unsigned WordWidth = DefWordWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [KindW-1:0] kind_i,
  input  wire logic [PosW-1:0]  position_i,
  input  wire logic [DataW-1:0] value_i,
  input  wire logic             capacity_we_i,
  input  wire logic [CapW-1:0]  capacity_i,
  output logic                  done_o,
  output logic [StatW-1:0]      status_o,
  output logic [DataW-1:0]      data_o,
  output logic                  last_o,
  output logic [LenW-1:0]       length_o
);
  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [LenW-1:0] count;
  logic [CapW-1:0] cap_q;

  // capacity register, reset to 16 (the default depth)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapW'(16);
    else if (capacity_we_i) cap_q <= capacity_i;
  end

  sle_ctrl #(.Depth(Depth)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .kind_i, .position_i,
    .capacity_i(cap_q), .count_i(count), .stat_i(stat),
    .cmd_o(cmd), .busy_o(busy)
  );

  sle_datapath #(.Depth(Depth), .WordWidth(WordWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .value_i, .stat_o(stat), .count_o(count),
    .done_o, .status_o, .data_o, .last_o
  );

  // length follows the count after the command completes
  assign length_o = count;
endmodule
`default_nettype wire
